>>> src/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants for the hall sector decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int unsigned SECTORS      = 6;
    localparam int unsigned WRAP_STEPS   = 3;
    localparam int unsigned CFG_INDEX_W  = 1;
    localparam int unsigned CFG_DATA_W   = 32;

    localparam logic [2:0]  SECTOR_UNKNOWN    = 3'd7;
    localparam logic [31:0] SECTOR_TABLE_INIT = 32'hF312_540F;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_TABLE = 1'd1;

    typedef struct packed {
        logic [2:0]         sector;
        logic               rotating_ccw;
        logic signed [31:0] rotations;
        logic [31:0]        edge_period;
        logic [31:0]        edge_count;
        logic               sector_changed;
    } result_t;

endpackage

>>> src/hsd_cfg.sv
// ----------------------------------------------------------------------------
// hsd_cfg
// Configuration registers: sector offset and hall code to sector table.
// ----------------------------------------------------------------------------
module hsd_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [hsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hsd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [2:0]                       phase_offset,
    output logic [31:0]                      sector_table
);

    logic [2:0]  offset_reg;
    logic [31:0] table_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= 3'd0;
            table_reg  <= hsd_pkg::SECTOR_TABLE_INIT;
        end else if (cfg_we) begin
            case (cfg_index)
                hsd_pkg::REG_PHASE_OFFSET: offset_reg <= cfg_data[2:0];
                hsd_pkg::REG_SECTOR_TABLE: table_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign phase_offset = offset_reg;
    assign sector_table = table_reg;

endmodule

>>> src/hsd_core.sv
// ----------------------------------------------------------------------------
// hsd_core
// Decoder state and its combinational update for one hall sample, registered on step.
// ----------------------------------------------------------------------------
module hsd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [2:0]       hall_code,
    input  logic [31:0]      time_us,
    input  logic [2:0]       phase_offset,
    input  logic [31:0]      sector_table,
    output hsd_pkg::result_t result
);

    // last code: valid flag replaces the "none seen" encoding
    logic        code_seen_reg, code_seen_next;
    logic [2:0]  last_code_reg, last_code_next;
    logic        known_reg, known_next;
    logic [2:0]  sector_reg, sector_next;
    logic        dir_reg, dir_next;
    logic        prev_dir_reg, prev_dir_next;
    logic [31:0] rot_reg, rot_next;
    logic [31:0] edge_time_reg, edge_time_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] edges_reg, edges_next;

    logic        changed;
    logic [3:0]  base;
    logic [3:0]  sum;
    logic [2:0]  ns;
    logic signed [3:0] dif;

    always_comb begin
        base = sector_table[{hall_code, 2'b00} +: 4];
        sum  = base + {1'b0, phase_offset};
        if (sum >= 4'(2 * hsd_pkg::SECTORS)) begin
            ns = 3'(sum - 4'(2 * hsd_pkg::SECTORS));
        end else if (sum >= 4'(hsd_pkg::SECTORS)) begin
            ns = 3'(sum - 4'(hsd_pkg::SECTORS));
        end else begin
            ns = sum[2:0];
        end
        dif = $signed({1'b0, ns}) - $signed({1'b0, sector_reg});

        code_seen_next = code_seen_reg;
        last_code_next = last_code_reg;
        known_next     = known_reg;
        sector_next    = sector_reg;
        dir_next       = dir_reg;
        prev_dir_next  = prev_dir_reg;
        rot_next       = rot_reg;
        edge_time_next = edge_time_reg;
        period_next    = period_reg;
        edges_next     = edges_reg;
        changed        = 1'b0;

        if (!code_seen_reg || hall_code != last_code_reg) begin
            code_seen_next = 1'b1;
            last_code_next = hall_code;
            edge_time_next = time_us;
            edges_next     = edges_reg + 32'd1;
            if (base >= 4'(hsd_pkg::SECTORS)) begin
                known_next = 1'b0;
            end else begin
                if (known_reg) begin
                    if (dif > 4'sd3) begin
                        dir_next = 1'b1;
                        rot_next = rot_reg - 32'd1;
                    end else if (dif < -4'sd3) begin
                        dir_next = 1'b0;
                        rot_next = rot_reg + 32'd1;
                    end else begin
                        dir_next = (ns > sector_reg) ? 1'b0 : 1'b1;
                    end
                end
                known_next    = 1'b1;
                sector_next   = ns;
                period_next   = (dir_next == prev_dir_reg) ? time_us - edge_time_reg : 32'd0;
                prev_dir_next = dir_next;
                changed       = 1'b1;
            end
        end

        result.sector         = known_next ? sector_next : hsd_pkg::SECTOR_UNKNOWN;
        result.rotating_ccw   = dir_next;
        result.rotations      = $signed(rot_next);
        result.edge_period    = period_next;
        result.edge_count     = edges_next;
        result.sector_changed = changed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_seen_reg <= 1'b0;
            last_code_reg <= 3'd0;
            known_reg     <= 1'b0;
            sector_reg    <= 3'd0;
            dir_reg       <= 1'b0;
            prev_dir_reg  <= 1'b0;
            rot_reg       <= 32'd0;
            edge_time_reg <= 32'd0;
            period_reg    <= 32'd0;
            edges_reg     <= 32'd0;
        end else if (step) begin
            code_seen_reg <= code_seen_next;
            last_code_reg <= last_code_next;
            known_reg     <= known_next;
            sector_reg    <= sector_next;
            dir_reg       <= dir_next;
            prev_dir_reg  <= prev_dir_next;
            rot_reg       <= rot_next;
            edge_time_reg <= edge_time_next;
            period_reg    <= period_next;
            edges_reg     <= edges_next;
        end
    end

endmodule

>>> src/hall_sector_decoder.sv
// ----------------------------------------------------------------------------
// hall_sector_decoder
// Three-phase hall sensor decoder: sector, direction, rotations, edge period.
// ----------------------------------------------------------------------------
// Registers: the input register takes a transaction, the result register its result.
// Throughput: one transaction per cycle while m_ready is high; the state update
// is a loop in hsd_core between the input and result registers.
// Reset (aresetn low, synchronous): pipeline empty, sector unknown, counters
// zero, sector table 0xF312540F, offset 0.
module hall_sector_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_we,
    input  logic [hsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hsd_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_hall_a,
    input  logic                             s_hall_b,
    input  logic                             s_hall_c,
    input  logic [31:0]                      s_time_us,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_sector,
    output logic                             m_rotating_ccw,
    output logic signed [31:0]               m_rotations,
    output logic [31:0]                      m_edge_period,
    output logic [31:0]                      m_edge_count,
    output logic                             m_sector_changed
);

    logic             in_valid_reg, in_valid_next;
    logic [2:0]       code_reg;
    logic [31:0]      time_reg;
    logic             out_valid_reg, out_valid_next;
    hsd_pkg::result_t result_reg;
    hsd_pkg::result_t result;
    logic             advance;
    logic [2:0]       phase_offset;
    logic [31:0]      sector_table;

    hsd_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .phase_offset  (phase_offset),
        .sector_table  (sector_table)
    );

    hsd_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .hall_code     (code_reg),
        .time_us       (time_reg),
        .phase_offset  (phase_offset),
        .sector_table  (sector_table),
        .result        (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            code_reg <= {s_hall_a, s_hall_b, s_hall_c};
            time_reg <= s_time_us;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_sector         = result_reg.sector;
    assign m_rotating_ccw   = result_reg.rotating_ccw;
    assign m_rotations      = result_reg.rotations;
    assign m_edge_period    = result_reg.edge_period;
    assign m_edge_count     = result_reg.edge_count;
    assign m_sector_changed = result_reg.sector_changed;

endmodule
